/* hdl/stok_pkg.sv */
package stok_pkg;

    // Width of the position, length, line and column counters.
    localparam int POS_BITS = 24;
    // Width of the position fields on the result channel.
    localparam int OUT_W = 24;
    // Entries in the queue between the lexer and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [OUT_W-1:0] out_pos_t;

    localparam pos_t POS_MAX = {POS_BITS{1'b1}};

    // Lexer modes: what kind of token is still open.
    typedef enum logic [3:0] {
        M_IDLE,
        M_NAME,
        M_NUMBER,
        M_OPEQ,
        M_OPPAIR,
        M_SLASH,
        M_COLON,
        M_LINECOM,
        M_BLOCKCOM
    } mode_t;

    // Token classes.
    localparam logic [3:0] CLS_COMMA   = 4'd0;
    localparam logic [3:0] CLS_DOT     = 4'd1;
    localparam logic [3:0] CLS_NAME    = 4'd2;
    localparam logic [3:0] CLS_COMMENT = 4'd3;
    localparam logic [3:0] CLS_SEP     = 4'd4;
    localparam logic [3:0] CLS_SEMI    = 4'd5;
    localparam logic [3:0] CLS_DEF     = 4'd6;
    localparam logic [3:0] CLS_OP      = 4'd7;
    localparam logic [3:0] CLS_SCOPE   = 4'd8;
    localparam logic [3:0] CLS_NUMBER  = 4'd9;
    localparam logic [3:0] CLS_UNKNOWN = 4'd10;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_COLON   = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // One result item.
    typedef struct packed {
        logic [3:0] token_class;
        logic [1:0] error_code;
        out_pos_t   start_offset;
        out_pos_t   token_length;
        out_pos_t   line_number;
        out_pos_t   column_number;
        out_pos_t   newline_count;
        logic       last_of_run;
        logic       final_token;
    } result_t;

    // Everything one input byte produces: up to two result items.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

    // Counters touched when a byte joins the open token.
    typedef struct packed {
        pos_t tlen;
        pos_t tnl;
        pos_t cline;
        pos_t lso;
    } ctr_t;

    function automatic pos_t sat_inc(pos_t v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_id_first(logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_id_more(logic [7:0] c);
        return is_id_first(c) || is_digit(c);
    endfunction

    function automatic logic is_num_more(logic [7:0] c);
        return is_digit(c) || (c == CH_QUOTE) || (c == CH_UNDER);
    endfunction

    // Add one byte to the open token; a newline also opens a new line.
    function automatic ctr_t take_byte(ctr_t c, logic [7:0] b, pos_t boff);
        ctr_t r;
        r = c;
        r.tlen = sat_inc(c.tlen);
        if (b == CH_NL)
        begin
            r.tnl = sat_inc(c.tnl);
            r.cline = sat_inc(c.cline);
            r.lso = sat_inc(boff);
        end
        return r;
    endfunction

    // Build one result item from the open token's fields.
    function automatic result_t make_result(logic [3:0] cls, logic [1:0] err, logic fin,
                                            pos_t tstart, pos_t tlen, pos_t tline,
                                            pos_t tcol, pos_t tnl);
        result_t r;
        r.token_class = cls;
        r.error_code = err;
        r.start_offset = OUT_W'(tstart);
        r.token_length = OUT_W'(tlen);
        r.line_number = OUT_W'(tline);
        r.column_number = OUT_W'(tcol);
        r.newline_count = OUT_W'(tnl);
        r.last_of_run = 1'b0;
        r.final_token = fin;
        return r;
    endfunction

endpackage

/* hdl/stok_byte_if.sv */
interface stok_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/stok_token_if.sv */
interface stok_token_if
    import stok_pkg::*;
();

    logic       valid;
    logic       ready;
    logic [3:0] token_class;
    logic [1:0] error_code;
    out_pos_t   start_offset;
    out_pos_t   token_length;
    out_pos_t   line_number;
    out_pos_t   column_number;
    out_pos_t   newline_count;
    logic       last_of_run;
    logic       final_token;

    modport source (output valid, output token_class, output error_code,
                    output start_offset, output token_length, output line_number,
                    output column_number, output newline_count, output last_of_run,
                    output final_token, input ready);
    modport sink (input valid, input token_class, input error_code,
                  input start_offset, input token_length, input line_number,
                  input column_number, input newline_count, input last_of_run,
                  input final_token, output ready);
endinterface

/* hdl/source_tokenizer.sv */
// A result item is registered in the queue and then in the output register before it is offered.
// Throughput: one byte per cycle; the output stage sends one item per cycle while tokens.ready
// is high, so a byte that yields two items holds it for both, absorbed by a four-entry queue.
// Byte acceptance stalls only when that queue is full.
// Reset (rst_n, asynchronous, active low) clears the lexer to the start of a text at
// offset 0, line 1, and empties the queue and output stage.
module source_tokenizer
    import stok_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    stok_byte_if.sink     text,
    stok_token_if.source  tokens
);

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    entry_t push_data;
    entry_t head;

    // Lexer: classifies bytes and builds result items.
    stok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Queue between lexer and output stage.
    stok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    // Output stage: sends the items of each entry in order.
    stok_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (q_empty),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule

/* hdl/stok_front.sv */
module stok_front
    import stok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stok_byte_if.sink   text,
    input  logic        q_full,
    output logic        push,
    output entry_t      push_data
);

    mode_t      mode_reg, mode_next;
    logic [7:0] pend_reg, pend_next;
    pos_t       tstart_reg, tstart_next;
    pos_t       boff_reg, boff_next;
    pos_t       tline_reg, tline_next;
    pos_t       tcol_reg, tcol_next;
    ctr_t       ctr_reg, ctr_next;
    logic       star_reg, star_next;
    logic       halt_reg, halt_next;

    logic       accept;
    result_t    res [2];
    logic [1:0] cnt;

    // A byte is taken whenever the queue can hold what it produces.
    assign text.ready = ~q_full;
    assign accept = text.valid & ~q_full;

    // Lexer step for one byte: offer it to the open token, then start a new
    // token with it if it was not used, then close the text on the last byte.
    always_comb
    begin
        logic [7:0] b;
        logic       used;
        logic       f_take;
        logic       f_emit;
        logic [3:0] f_cls;
        logic [1:0] f_err;
        logic       f_fin;
        logic       s_emit;
        logic [3:0] s_cls;
        logic [1:0] s_err;
        logic       fl_emit;
        logic [3:0] fl_cls;
        logic [1:0] fl_err;

        b = text.data_byte;
        mode_next = mode_reg;
        pend_next = pend_reg;
        tstart_next = tstart_reg;
        boff_next = boff_reg;
        tline_next = tline_reg;
        tcol_next = tcol_reg;
        ctr_next = ctr_reg;
        star_next = star_reg;
        halt_next = halt_reg;
        res[0] = '0;
        res[1] = '0;
        cnt = 2'd0;
        used = 1'b0;
        f_take = 1'b0;
        f_emit = 1'b0;
        f_cls = CLS_OP;
        f_err = ERR_NONE;
        f_fin = 1'b0;
        s_emit = 1'b0;
        s_cls = CLS_SEP;
        s_err = ERR_NONE;
        fl_emit = 1'b0;
        fl_cls = CLS_OP;
        fl_err = ERR_NONE;

        if (halt_reg)
        begin
            // After an error every byte is dropped until the last one.
            if (text.last_byte)
            begin
                mode_next = M_IDLE;
                pend_next = '0;
                tstart_next = '0;
                boff_next = '0;
                tline_next = pos_t'(1);
                tcol_next = pos_t'(1);
                ctr_next.tlen = '0;
                ctr_next.tnl = '0;
                ctr_next.cline = pos_t'(1);
                ctr_next.lso = '0;
                star_next = 1'b0;
                halt_next = 1'b0;
            end
        end
        else
        begin
            // Offer the byte to the open token.
            case (mode_reg)
                M_NAME:
                begin
                    if (is_id_more(b))
                    begin
                        f_take = 1'b1;
                        used = 1'b1;
                    end
                    else
                    begin
                        f_emit = 1'b1;
                        f_cls = CLS_NAME;
                    end
                end
                M_NUMBER:
                begin
                    if (is_num_more(b))
                    begin
                        f_take = 1'b1;
                        used = 1'b1;
                    end
                    else
                    begin
                        f_emit = 1'b1;
                        f_cls = CLS_NUMBER;
                    end
                end
                M_OPEQ:
                begin
                    f_emit = 1'b1;
                    if (b == CH_EQ)
                    begin
                        f_take = 1'b1;
                        used = 1'b1;
                    end
                end
                M_OPPAIR:
                begin
                    f_emit = 1'b1;
                    if ((b == CH_EQ) || (b == pend_reg))
                    begin
                        f_take = 1'b1;
                        used = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (b == CH_SLASH)
                    begin
                        f_take = 1'b1;
                        used = 1'b1;
                        mode_next = M_LINECOM;
                    end
                    else if (b == CH_STAR)
                    begin
                        f_take = 1'b1;
                        used = 1'b1;
                        mode_next = M_BLOCKCOM;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        f_emit = 1'b1;
                        if (b == CH_EQ)
                        begin
                            f_take = 1'b1;
                            used = 1'b1;
                        end
                    end
                end
                M_COLON:
                begin
                    f_emit = 1'b1;
                    used = 1'b1;
                    if (b == CH_COLON)
                    begin
                        f_take = 1'b1;
                        f_cls = CLS_DEF;
                    end
                    else
                    begin
                        // A lone colon stops the text; this byte is dropped.
                        f_cls = CLS_UNKNOWN;
                        f_err = ERR_COLON;
                        f_fin = 1'b1;
                        halt_next = 1'b1;
                    end
                end
                M_LINECOM:
                begin
                    if (b == CH_NL)
                    begin
                        f_emit = 1'b1;
                        f_cls = CLS_COMMENT;
                    end
                    else
                    begin
                        f_take = 1'b1;
                        used = 1'b1;
                    end
                end
                M_BLOCKCOM:
                begin
                    f_take = 1'b1;
                    used = 1'b1;
                    if (star_reg && (b == CH_SLASH))
                    begin
                        star_next = 1'b0;
                        f_emit = 1'b1;
                        f_cls = CLS_COMMENT;
                    end
                    else
                    begin
                        star_next = (b == CH_STAR);
                    end
                end
                default:
                begin
                    used = 1'b0;
                end
            endcase

            if (f_take)
            begin
                ctr_next = take_byte(ctr_next, b, boff_reg);
            end
            if (f_emit)
            begin
                res[cnt[0]] = make_result(f_cls, f_err, f_fin, tstart_next, ctr_next.tlen,
                                          tline_next, tcol_next, ctr_next.tnl);
                cnt = cnt + 2'd1;
                mode_next = M_IDLE;
            end

            // Start a new token with a byte the open token did not use.
            if (!used)
            begin
                tstart_next = boff_reg;
                tline_next = ctr_next.cline;
                tcol_next = sat_inc(boff_reg - ctr_next.lso);
                ctr_next.tnl = '0;
                ctr_next.tlen = '0;
                ctr_next = take_byte(ctr_next, b, boff_reg);
                case (b)
                    CH_COMMA:
                    begin
                        s_emit = 1'b1;
                        s_cls = CLS_COMMA;
                    end
                    CH_DOT:
                    begin
                        s_emit = 1'b1;
                        s_cls = CLS_DOT;
                    end
                    CH_SEMI:
                    begin
                        s_emit = 1'b1;
                        s_cls = CLS_SEMI;
                    end
                    CH_SPACE, CH_TAB, CH_CR, CH_NL:
                    begin
                        s_emit = 1'b1;
                        s_cls = CLS_SEP;
                    end
                    CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK:
                    begin
                        s_emit = 1'b1;
                        s_cls = CLS_SCOPE;
                    end
                    CH_STAR, CH_PLUS, CH_MINUS, CH_PCT, CH_BANG, CH_TILDE:
                    begin
                        mode_next = M_OPEQ;
                    end
                    CH_EQ, CH_AMP, CH_PIPE, CH_GT, CH_LT:
                    begin
                        mode_next = M_OPPAIR;
                        pend_next = b;
                    end
                    CH_SLASH:
                    begin
                        mode_next = M_SLASH;
                    end
                    CH_COLON:
                    begin
                        mode_next = M_COLON;
                    end
                    default:
                    begin
                        if (is_id_first(b))
                        begin
                            mode_next = M_NAME;
                        end
                        else if (is_digit(b))
                        begin
                            mode_next = M_NUMBER;
                        end
                        else
                        begin
                            s_emit = 1'b1;
                            s_cls = CLS_UNKNOWN;
                            s_err = ERR_UNKNOWN;
                            halt_next = 1'b1;
                        end
                    end
                endcase
                if (s_emit)
                begin
                    res[cnt[0]] = make_result(s_cls, s_err, halt_next, tstart_next,
                                              ctr_next.tlen, tline_next, tcol_next,
                                              ctr_next.tnl);
                    cnt = cnt + 2'd1;
                    mode_next = M_IDLE;
                end
            end

            boff_next = sat_inc(boff_reg);

            // The last byte closes any open token and resets the text position.
            if (text.last_byte)
            begin
                if (!halt_next)
                begin
                    case (mode_next)
                        M_NAME:
                        begin
                            fl_emit = 1'b1;
                            fl_cls = CLS_NAME;
                        end
                        M_NUMBER:
                        begin
                            fl_emit = 1'b1;
                            fl_cls = CLS_NUMBER;
                        end
                        M_OPEQ, M_OPPAIR, M_SLASH:
                        begin
                            fl_emit = 1'b1;
                            fl_cls = CLS_OP;
                        end
                        M_COLON:
                        begin
                            fl_emit = 1'b1;
                            fl_cls = CLS_UNKNOWN;
                            fl_err = ERR_COLON;
                        end
                        M_LINECOM, M_BLOCKCOM:
                        begin
                            fl_emit = 1'b1;
                            fl_cls = CLS_COMMENT;
                        end
                        default:
                        begin
                            fl_emit = 1'b0;
                        end
                    endcase
                    if (fl_emit)
                    begin
                        res[cnt[0]] = make_result(fl_cls, fl_err, 1'b1, tstart_next,
                                                  ctr_next.tlen, tline_next, tcol_next,
                                                  ctr_next.tnl);
                        cnt = cnt + 2'd1;
                    end
                    else if (cnt != 2'd0)
                    begin
                        res[1'(cnt - 2'd1)].final_token = 1'b1;
                    end
                end
                mode_next = M_IDLE;
                pend_next = '0;
                tstart_next = '0;
                boff_next = '0;
                tline_next = pos_t'(1);
                tcol_next = pos_t'(1);
                ctr_next.tlen = '0;
                ctr_next.tnl = '0;
                ctr_next.cline = pos_t'(1);
                ctr_next.lso = '0;
                star_next = 1'b0;
                halt_next = 1'b0;
            end

            if (cnt != 2'd0)
            begin
                res[1'(cnt - 2'd1)].last_of_run = 1'b1;
            end
        end
    end

    // Queue write: one entry for every byte that gives at least one item.
    assign push = accept & (cnt != 2'd0);
    assign push_data.first = res[0];
    assign push_data.second = res[1];
    assign push_data.two = cnt[1];

    // Lexer state registers advance on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pend_reg <= '0;
            tstart_reg <= '0;
            boff_reg <= '0;
            tline_reg <= pos_t'(1);
            tcol_reg <= pos_t'(1);
            ctr_reg.tlen <= '0;
            ctr_reg.tnl <= '0;
            ctr_reg.cline <= pos_t'(1);
            ctr_reg.lso <= '0;
            star_reg <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            tstart_reg <= tstart_next;
            boff_reg <= boff_next;
            tline_reg <= tline_next;
            tcol_reg <= tcol_next;
            ctr_reg <= ctr_next;
            star_reg <= star_next;
            halt_reg <= halt_next;
        end
    end

endmodule

/* hdl/stok_queue.sv */
module stok_queue
    import stok_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    // QUEUE_DEPTH is a power of two, so the pointers wrap on their own.
    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop = pop & ~empty;
    assign head = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/stok_back.sv */
module stok_back
    import stok_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  entry_t        head,
    input  logic          empty,
    output logic          pop,
    stok_token_if.source  tokens
);

    entry_t  cur_reg, cur_next;
    logic    valid_reg, valid_next;
    logic    idx_reg, idx_next;
    logic    out_done;
    logic    entry_done;
    result_t sel;

    // Present the first item of the held entry, then the second if there is one.
    assign sel = idx_reg ? cur_reg.second : cur_reg.first;
    assign out_done = valid_reg & tokens.ready;
    assign entry_done = out_done & (idx_reg | ~cur_reg.two);
    assign pop = (~valid_reg | entry_done) & ~empty;

    // Output register control: load a new entry when none is held or the held one is finished.
    always_comb
    begin
        cur_next = cur_reg;
        valid_next = valid_reg;
        idx_next = idx_reg;
        if (!valid_reg || entry_done)
        begin
            cur_next = head;
            valid_next = ~empty;
            idx_next = 1'b0;
        end
        else if (out_done)
        begin
            idx_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign tokens.valid = valid_reg;
    assign tokens.token_class = sel.token_class;
    assign tokens.error_code = sel.error_code;
    assign tokens.start_offset = sel.start_offset;
    assign tokens.token_length = sel.token_length;
    assign tokens.line_number = sel.line_number;
    assign tokens.column_number = sel.column_number;
    assign tokens.newline_count = sel.newline_count;
    assign tokens.last_of_run = sel.last_of_run;
    assign tokens.final_token = sel.final_token;

endmodule
